[src/assert_macros.svh]
// Assertion macros shared by the RTL; define NO_ASSERTIONS to drop them all.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, switched off while reset is high.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

[src/t16c_pkg.sv]
// Shared constants, opcodes and the result type of the teaching CPU.
`timescale 1ns / 1ps
package t16c_pkg;

  localparam int DATA_W    = 16;
  localparam int ADDR_W    = 8;
  localparam int MEM_WORDS = 256;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_COUNT = 16;
  localparam int REG_AW    = $clog2(REG_COUNT);

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_EXEC = 1'b1;

  localparam logic [3:0] OP_LDI = 4'h1;
  localparam logic [3:0] OP_MOV = 4'h2;
  localparam logic [3:0] OP_LDM = 4'h3;
  localparam logic [3:0] OP_STM = 4'h4;
  localparam logic [3:0] OP_ADD = 4'h6;
  localparam logic [3:0] OP_NEG = 4'h7;
  localparam logic [3:0] OP_SHR = 4'h8;
  localparam logic [3:0] OP_SHL = 4'h9;
  localparam logic [3:0] OP_AND = 4'hA;
  localparam logic [3:0] OP_OR  = 4'hB;
  localparam logic [3:0] OP_XOR = 4'hC;
  localparam logic [3:0] OP_JMP = 4'hD;
  localparam logic [3:0] OP_HLT = 4'hE;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] program_counter;
    logic              halted;
    logic              reg_written;
    logic [REG_AW-1:0] reg_index;
    logic [DATA_W-1:0] reg_value;
    logic              mem_written;
    logic [ADDR_W-1:0] mem_address;
    logic [DATA_W-1:0] mem_value;
    logic              branch_taken;
  } result_t;

  // Opcodes whose first register operand is Ra rather than Rb.
  function automatic logic uses_ra(input logic [3:0] op);
    return (op == OP_STM) || (op == OP_SHR) || (op == OP_SHL) || (op == OP_JMP);
  endfunction

endpackage

[src/t16c_mem.sv]
// Main memory: one write port, one registered read port, per-word valid bits.
`timescale 1ns / 1ps
module t16c_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           re,
  input  logic [t16c_pkg::MEM_AW-1:0]    raddr,
  output logic [t16c_pkg::DATA_W-1:0]    rdata,
  input  logic                           we,
  input  logic [t16c_pkg::MEM_AW-1:0]    waddr,
  input  logic [t16c_pkg::DATA_W-1:0]    wdata
);
  import t16c_pkg::*;

  logic [DATA_W-1:0]    mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld;
  logic [DATA_W-1:0]    rdata_q;
  logic                 rvld_q;

  // A word never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
      rvld_q  <= vld[raddr];
    end
  end

  assign rdata = rvld_q ? rdata_q : '0;

endmodule

[src/t16c_rf.sv]
// Register file: two registered read ports, one write port, R0 kept in a shadow register.
`timescale 1ns / 1ps
module t16c_rf (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           re,
  input  logic [t16c_pkg::REG_AW-1:0]    raddr_x,
  input  logic [t16c_pkg::REG_AW-1:0]    raddr_c,
  output logic [t16c_pkg::DATA_W-1:0]    rdata_x,
  output logic [t16c_pkg::DATA_W-1:0]    rdata_c,
  output logic [t16c_pkg::DATA_W-1:0]    r0,
  input  logic                           we,
  input  logic [t16c_pkg::REG_AW-1:0]    widx,
  input  logic [t16c_pkg::DATA_W-1:0]    wdata
);
  import t16c_pkg::*;

  logic [DATA_W-1:0]    regs [REG_COUNT];
  logic [REG_COUNT-1:0] vld;
  logic [DATA_W-1:0]    x_q;
  logic [DATA_W-1:0]    c_q;
  logic                 x_vld_q;
  logic                 c_vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      r0  <= '0;
    end else if (we) begin
      vld[widx] <= 1'b1;
      if (widx == '0) begin
        r0 <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      regs[widx] <= wdata;
    end
    if (re) begin
      x_q     <= regs[raddr_x];
      c_q     <= regs[raddr_c];
      x_vld_q <= vld[raddr_x];
      c_vld_q <= vld[raddr_c];
    end
  end

  assign rdata_x = x_vld_q ? x_q : '0;
  assign rdata_c = c_vld_q ? c_q : '0;

endmodule

[src/t16c_exec.sv]
// Execute unit: works out the result, the writebacks and the next PC of one item.
`timescale 1ns / 1ps
module t16c_exec (
  input  logic                           func,
  input  logic [t16c_pkg::ADDR_W-1:0]    load_address,
  input  logic [t16c_pkg::DATA_W-1:0]    load_word,
  input  logic [t16c_pkg::DATA_W-1:0]    ir,
  input  logic [t16c_pkg::DATA_W-1:0]    opx,
  input  logic [t16c_pkg::DATA_W-1:0]    opc,
  input  logic [t16c_pkg::DATA_W-1:0]    r0,
  input  logic [t16c_pkg::DATA_W-1:0]    mdata,
  input  logic [t16c_pkg::ADDR_W-1:0]    pc,
  input  logic                           halt,
  output t16c_pkg::result_t              res
);
  import t16c_pkg::*;

  logic [3:0]        op;
  logic [REG_AW-1:0] fa;
  logic [REG_AW-1:0] fb;
  logic [3:0]        fc;
  logic [ADDR_W-1:0] bc;

  assign op = ir[15:12];
  assign fa = ir[11:8];
  assign fb = ir[7:4];
  assign fc = ir[3:0];
  assign bc = ir[7:0];

  // opx carries Rb, or Ra for the opcodes that name Ra as their source.
  always_comb begin
    res                 = '0;
    res.program_counter = pc;
    res.halted          = halt;
    if (func == FUNC_LOAD) begin
      res.mem_written = 1'b1;
      res.mem_address = load_address;
      res.mem_value   = load_word;
    end else if (!halt) begin
      res.program_counter = pc + ADDR_W'(1);
      unique case (op)
        OP_LDI: begin
          res.reg_written = 1'b1;
          res.reg_index   = fa;
          res.reg_value   = {{(DATA_W-ADDR_W){1'b0}}, bc};
        end
        OP_MOV: begin
          res.reg_written = 1'b1;
          res.reg_index   = fb;
          res.reg_value   = opc;
        end
        OP_LDM: begin
          res.reg_written = 1'b1;
          res.reg_index   = fa;
          res.reg_value   = mdata;
        end
        OP_STM: begin
          res.mem_written = 1'b1;
          res.mem_address = bc;
          res.mem_value   = opx;
        end
        OP_ADD: begin
          res.reg_written = 1'b1;
          res.reg_index   = fa;
          res.reg_value   = opx + opc;
        end
        OP_NEG: begin
          res.reg_written = 1'b1;
          res.reg_index   = fb;
          res.reg_value   = (~opx) + DATA_W'(1);
        end
        OP_SHR: begin
          res.reg_written = 1'b1;
          res.reg_index   = fa;
          res.reg_value   = opx >> fc;
        end
        OP_SHL: begin
          res.reg_written = 1'b1;
          res.reg_index   = fa;
          res.reg_value   = opx << fc;
        end
        OP_AND: begin
          res.reg_written = 1'b1;
          res.reg_index   = fa;
          res.reg_value   = opx & opc;
        end
        OP_OR: begin
          res.reg_written = 1'b1;
          res.reg_index   = fa;
          res.reg_value   = opx | opc;
        end
        OP_XOR: begin
          res.reg_written = 1'b1;
          res.reg_index   = fa;
          res.reg_value   = opx ^ opc;
        end
        OP_JMP: begin
          if (opx == r0) begin
            res.branch_taken    = 1'b1;
            res.program_counter = bc;
          end
        end
        OP_HLT: begin
          res.halted          = 1'b1;
          res.program_counter = pc;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[src/tiny_16bit_cpu_step_top.sv]
// Top level of the teaching CPU step engine: sequencer, PC, halt flag, beat registers.
// An accepted beat waits in the input beat register; its item then passes the fetch, decode and
// execute states (fetch, operand read, writeback), bound by the one memory read port, and waits in
// execute while a held result beat is stalled; a new input beat is taken while the previous item is still in flight.
// Reset (synchronous, rst high) clears PC, halt flag, sequencer and the memory and register
// valid bits, so every word and register reads as zero until written; no clearing pass.
`timescale 1ns / 1ps
module tiny_16bit_cpu_step_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           func,
  input  logic [t16c_pkg::ADDR_W-1:0]    load_address,
  input  logic [t16c_pkg::DATA_W-1:0]    load_word,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [t16c_pkg::ADDR_W-1:0]    program_counter,
  output logic                           halted,
  output logic                           reg_written,
  output logic [t16c_pkg::REG_AW-1:0]    reg_index,
  output logic [t16c_pkg::DATA_W-1:0]    reg_value,
  output logic                           mem_written,
  output logic [t16c_pkg::ADDR_W-1:0]    mem_address,
  output logic [t16c_pkg::DATA_W-1:0]    mem_value,
  output logic                           branch_taken
);
  import t16c_pkg::*;
  `include "assert_macros.svh"

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] pc;
  logic              halt;

  logic              hold_vld;
  logic              hold_func;
  logic [ADDR_W-1:0] hold_addr;
  logic [DATA_W-1:0] hold_word;
  logic              cur_func;
  logic [ADDR_W-1:0] cur_addr;
  logic [DATA_W-1:0] cur_word;
  logic [DATA_W-1:0] ir_q;

  logic              accept;
  logic              start;
  logic              commit;
  logic              mem_re;
  logic              rf_re;
  logic [MEM_AW-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic [REG_AW-1:0] rf_addr_x;
  logic [DATA_W-1:0] opx;
  logic [DATA_W-1:0] opc;
  logic [DATA_W-1:0] r0;
  result_t           res;
  result_t           out_q;

  // Input beat register: holds the next item while the current one is worked on.
  assign item_stall = hold_vld && !start;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (accept) begin
      hold_vld <= 1'b1;
    end else if (start) begin
      hold_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_func <= func;
      hold_addr <= load_address;
      hold_word <= load_word;
    end
    if (start) begin
      cur_func <= hold_func;
      cur_addr <= hold_addr;
      cur_word <= hold_word;
    end
    if (state == ST_DECODE) begin
      ir_q <= mem_rdata;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_DECODE;
      ST_DECODE: state_next = ST_EXEC;
      ST_EXEC: begin
        if (commit) begin
          state_next = start ? ST_FETCH : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs. Only one item is in flight, so the writeback of one item always
  // lands before the fetch of the next and no forwarding is needed.
  always_comb begin
    commit    = (state == ST_EXEC) && (!result_valid || !result_stall);
    start     = hold_vld && ((state == ST_IDLE) || commit);
    mem_re    = (state == ST_FETCH) || (state == ST_DECODE);
    rf_re     = (state == ST_DECODE);
    mem_raddr = (state == ST_FETCH) ? pc[MEM_AW-1:0] : mem_rdata[MEM_AW-1:0];
    rf_addr_x = uses_ra(mem_rdata[15:12]) ? mem_rdata[11:8] : mem_rdata[7:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      halt  <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        pc   <= res.program_counter;
        halt <= res.halted;
      end
    end
  end

  t16c_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (commit && res.mem_written),
    .waddr (res.mem_address[MEM_AW-1:0]),
    .wdata (res.mem_value)
  );

  t16c_rf u_rf (
    .clk     (clk),
    .rst     (rst),
    .re      (rf_re),
    .raddr_x (rf_addr_x),
    .raddr_c (mem_rdata[3:0]),
    .rdata_x (opx),
    .rdata_c (opc),
    .r0      (r0),
    .we      (commit && res.reg_written),
    .widx    (res.reg_index),
    .wdata   (res.reg_value)
  );

  t16c_exec u_exec (
    .func         (cur_func),
    .load_address (cur_addr),
    .load_word    (cur_word),
    .ir           (ir_q),
    .opx          (opx),
    .opc          (opc),
    .r0           (r0),
    .mdata        (mem_rdata),
    .pc           (pc),
    .halt         (halt),
    .res          (res)
  );

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_q <= res;
    end
  end

  assign program_counter = out_q.program_counter;
  assign halted          = out_q.halted;
  assign reg_written     = out_q.reg_written;
  assign reg_index       = out_q.reg_index;
  assign reg_value       = out_q.reg_value;
  assign mem_written     = out_q.mem_written;
  assign mem_address     = out_q.mem_address;
  assign mem_value       = out_q.mem_value;
  assign branch_taken    = out_q.branch_taken;

  `ASSERT_CLK(a_no_mem_rw_overlap, clk, rst, !(commit && res.mem_written && mem_re), "memory written while a read is in flight")
  `ASSERT_CLK(a_halt_sticky, clk, rst, halt |=> halt, "halt flag cleared without reset")
  `ASSERT_CLK(a_halted_pc_holds, clk, rst, (commit && halt) |=> (pc == $past(pc)), "program counter moved while halted")
  `ASSERT_ALWAYS(a_commit_needs_slot, clk, commit |-> !(result_valid && result_stall), "result overwritten before it was taken")

endmodule

[test/tiny_16bit_cpu_step_top_tb.sv]
// Self-checking testbench for the teaching CPU step engine, with its own step predictor.
`timescale 1ns / 1ps
module tiny_16bit_cpu_step_top_tb;
  import t16c_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 607;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic              func;
    logic              at_pc;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] word;
    logic              typed;
    result_t           want;
  } row_t;

  localparam result_t NO_RES = '0;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic                func = 1'b0;
  logic [ADDR_W-1:0]   load_address = '0;
  logic [DATA_W-1:0]   load_word = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [ADDR_W-1:0]   program_counter;
  logic                halted;
  logic                reg_written;
  logic [REG_AW-1:0]   reg_index;
  logic [DATA_W-1:0]   reg_value;
  logic                mem_written;
  logic [ADDR_W-1:0]   mem_address;
  logic [DATA_W-1:0]   mem_value;
  logic                branch_taken;

  // Predictor state.
  logic [DATA_W-1:0]   memory_image [MEM_WORDS];
  logic [DATA_W-1:0]   register_image [REG_COUNT];
  logic [ADDR_W-1:0]   pc_model;
  logic                halt_model;

  result_t             step_results_due [$];
  row_t                rows [$];
  int                  send_idle_pct = 13;
  int                  recv_stall_pct = 53;
  int                  items_sent = 0;
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;

  tiny_16bit_cpu_step_top u_top (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .func            (func),
    .load_address    (load_address),
    .load_word       (load_word),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .program_counter (program_counter),
    .halted          (halted),
    .reg_written     (reg_written),
    .reg_index       (reg_index),
    .reg_value       (reg_value),
    .mem_written     (mem_written),
    .mem_address     (mem_address),
    .mem_value       (mem_value),
    .branch_taken    (branch_taken)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t result_of(input logic [ADDR_W-1:0] pc, input logic hlt,
                                        input logic rw, input logic [REG_AW-1:0] ri,
                                        input logic [DATA_W-1:0] rv, input logic mw,
                                        input logic [ADDR_W-1:0] ma,
                                        input logic [DATA_W-1:0] mv, input logic br);
    return {pc, hlt, rw, ri, rv, mw, ma, mv, br};
  endfunction

  // Applies one beat to the predictor state and returns the result it should produce.
  function automatic result_t execute_step(input logic f, input logic [ADDR_W-1:0] la,
                                           input logic [DATA_W-1:0] lw);
    result_t           r;
    logic [DATA_W-1:0] ir, ra, rb, rc;
    logic [3:0]        op, ia, ib, ic;
    logic [7:0]        bc;
    logic [ADDR_W-1:0] nxt;
    r = '0;
    if (f == FUNC_LOAD) begin
      memory_image[la] = lw;
      r.mem_written = 1'b1;
      r.mem_address = la;
      r.mem_value   = lw;
    end else if (!halt_model) begin
      ir = memory_image[pc_model];
      {op, ia, ib, ic} = ir;
      bc  = ir[7:0];
      ra  = register_image[ia];
      rb  = register_image[ib];
      rc  = register_image[ic];
      nxt = pc_model + 1'b1;
      case (op)
        OP_LDI: begin r.reg_written = 1'b1; r.reg_index = ia; r.reg_value = {8'h00, bc}; end
        OP_MOV: begin r.reg_written = 1'b1; r.reg_index = ib; r.reg_value = rc; end
        OP_LDM: begin
          r.reg_written = 1'b1;
          r.reg_index   = ia;
          r.reg_value   = memory_image[bc];
        end
        OP_STM: begin
          r.mem_written = 1'b1;
          r.mem_address = bc;
          r.mem_value   = ra;
          memory_image[bc] = ra;
        end
        OP_ADD: begin r.reg_written = 1'b1; r.reg_index = ia; r.reg_value = rb + rc; end
        OP_NEG: begin r.reg_written = 1'b1; r.reg_index = ib; r.reg_value = ~rb + 1'b1; end
        OP_SHR: begin r.reg_written = 1'b1; r.reg_index = ia; r.reg_value = ra >> ic; end
        OP_SHL: begin r.reg_written = 1'b1; r.reg_index = ia; r.reg_value = ra << ic; end
        OP_AND: begin r.reg_written = 1'b1; r.reg_index = ia; r.reg_value = rb & rc; end
        OP_OR:  begin r.reg_written = 1'b1; r.reg_index = ia; r.reg_value = rb | rc; end
        OP_XOR: begin r.reg_written = 1'b1; r.reg_index = ia; r.reg_value = rb ^ rc; end
        OP_JMP: begin
          if (ra == register_image[0]) begin
            r.branch_taken = 1'b1;
            nxt = bc;
          end
        end
        OP_HLT: begin
          halt_model = 1'b1;
          nxt = pc_model;
        end
        default: begin
        end
      endcase
      if (r.reg_written) register_image[r.reg_index] = r.reg_value;
      pc_model = nxt;
    end
    r.program_counter = pc_model;
    r.halted          = halt_model;
    return r;
  endfunction

  // Any opcode but halt, since the halt flag can only be cleared by reset.
  function automatic logic [DATA_W-1:0] random_instruction();
    logic [DATA_W-1:0] w;
    w = 16'($urandom);
    while (w[15:12] == OP_HLT) w[15:12] = 4'($urandom);
    if (w[15:12] == OP_JMP) begin
      // Comparing R0 with itself always jumps; the high targets make the PC wrap.
      if ($urandom_range(1) == 0) w[11:8] = 4'h0;
      if ($urandom_range(3) == 0) w[7:0] = 8'($urandom_range(255, 248));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic send_item(input logic f, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] w, input logic typed, input result_t want);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    func         <= f;
    load_address <= a;
    load_word    <= w;
    do @(posedge clk); while (item_stall);
    pred = execute_step(f, a, w);
    step_results_due.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Holds the sender off until every due result beat has arrived.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (step_results_due.size() != 0);
  endtask

  task automatic walk_rows(input int first, input int last);
    row_t r;
    for (int i = first; i <= last; i++) begin
      r = rows[i];
      send_item(r.func, r.at_pc ? pc_model : r.addr, r.word, r.typed, r.want);
    end
  endtask

  task automatic run_random(input int count);
    int               stop_at, len, shape, skew;
    logic [ADDR_W-1:0] base;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      shape = $urandom_range(99);
      if (shape < 12) begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++)
          send_item(1'($urandom), 8'($urandom), random_instruction(), 1'b0, NO_RES);
      end else begin
        // A program loaded at the PC and then run; now and then it is misplaced.
        skew = (shape < 88) ? 0 : $urandom_range(3, 1);
        len  = $urandom_range(8, 1);
        base = pc_model + 8'(skew);
        for (int i = 0; i < len; i++)
          send_item(FUNC_LOAD, base + 8'(i), random_instruction(), 1'b0, NO_RES);
        for (int i = 0; i < len + $urandom_range(2); i++)
          send_item(FUNC_EXEC, 8'($urandom), 16'($urandom), 1'b0, NO_RES);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t got, want;
    result_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && result_valid && !result_stall) begin
      got = {program_counter, halted, reg_written, reg_index, reg_value,
             mem_written, mem_address, mem_value, branch_taken};
      if (step_results_due.size() == 0) begin
        report_mismatch("result beat with none due", got[31:0], 0);
      end else begin
        want = step_results_due.pop_front();
        check_field("program_counter", 32'(got.program_counter),
                    32'(want.program_counter));
        check_field("halted", 32'(got.halted), 32'(want.halted));
        check_field("reg_written", 32'(got.reg_written), 32'(want.reg_written));
        check_field("reg_index", 32'(got.reg_index), 32'(want.reg_index));
        check_field("reg_value", 32'(got.reg_value), 32'(want.reg_value));
        check_field("mem_written", 32'(got.mem_written), 32'(want.mem_written));
        check_field("mem_address", 32'(got.mem_address), 32'(want.mem_address));
        check_field("mem_value", 32'(got.mem_value), 32'(want.mem_value));
        check_field("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
      end
    end
    if (!rst && ((item_valid && !item_stall) || (result_valid && !result_stall)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[tiny_16bit_cpu_step_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] prog [1:12];
    for (int i = 0; i < MEM_WORDS; i++) memory_image[i] = '0;
    for (int i = 0; i < REG_COUNT; i++) register_image[i] = '0;
    pc_model   = '0;
    halt_model = 1'b0;

    // A short program that touches every operation but halt and the 16-bit extremes.
    prog[1]  = {OP_LDI, 4'hA, 8'h01};
    prog[2]  = {OP_NEG, 4'h0, 4'hA, 4'h0};
    prog[3]  = {OP_MOV, 4'h0, 4'hB, 4'hA};
    prog[4]  = {OP_ADD, 4'h1, 4'hA, 4'hB};
    prog[5]  = {OP_SHR, 4'h1, 4'h0, 4'hF};
    prog[6]  = {OP_SHL, 4'hB, 4'h0, 4'hF};
    prog[7]  = {OP_AND, 4'h4, 4'hA, 4'hB};
    prog[8]  = {OP_OR,  4'h5, 4'h1, 4'hB};
    prog[9]  = {OP_XOR, 4'h6, 4'hA, 4'h5};
    prog[10] = {OP_STM, 4'hA, 8'hFF};
    prog[11] = {OP_LDM, 4'h7, 8'hFF};
    prog[12] = {OP_JMP, 4'h8, 8'h20};

    // Executing the empty memory after reset only moves the PC on.
    rows.push_back({FUNC_EXEC, 1'b0, 8'h00, 16'h0000, 1'b1,
                    result_of(8'd1, 0, 0, 0, 0, 0, 0, 0, 0)});
    for (int i = 1; i <= 12; i++)
      rows.push_back({FUNC_LOAD, 1'b0, 8'(i), prog[i], 1'b1,
                      result_of(8'd1, 0, 0, 0, 0, 1, 8'(i), prog[i], 0)});
    rows.push_back({FUNC_EXEC, 1'b0, 8'h00, 16'h0000, 1'b1,
                    result_of(8'd2, 0, 1, 4'hA, 16'h0001, 0, 0, 0, 0)});
    rows.push_back({FUNC_EXEC, 1'b0, 8'hFF, 16'hFFFF, 1'b1,
                    result_of(8'd3, 0, 1, 4'hA, 16'hFFFF, 0, 0, 0, 0)});
    for (int i = 3; i <= 9; i++)
      rows.push_back({FUNC_EXEC, 1'b0, 8'(i), 16'h0000, 1'b0, NO_RES});
    rows.push_back({FUNC_EXEC, 1'b0, 8'h00, 16'h0000, 1'b1,
                    result_of(8'd11, 0, 0, 0, 0, 1, 8'hFF, 16'hFFFF, 0)});
    rows.push_back({FUNC_EXEC, 1'b0, 8'h00, 16'h0000, 1'b0, NO_RES});
    rows.push_back({FUNC_EXEC, 1'b0, 8'h00, 16'h0000, 1'b1,
                    result_of(8'h20, 0, 0, 0, 0, 0, 0, 0, 1)});
    // Run at the very end: halt at the PC, then execute and load while halted.
    rows.push_back({FUNC_LOAD, 1'b1, 8'h00, {OP_HLT, 12'h000}, 1'b0, NO_RES});
    rows.push_back({FUNC_EXEC, 1'b0, 8'h00, 16'h0000, 1'b0, NO_RES});
    rows.push_back({FUNC_EXEC, 1'b0, 8'h00, 16'h0000, 1'b0, NO_RES});
    rows.push_back({FUNC_LOAD, 1'b0, 8'hFF, 16'hFFFF, 1'b0, NO_RES});
    rows.push_back({FUNC_EXEC, 1'b0, 8'h00, 16'h0000, 1'b0, NO_RES});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    walk_rows(0, 24);
    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = (p == 0) ? 13 : (p == 1) ? 53 : 0;
      recv_stall_pct = (p == 0) ? 53 : (p == 1) ? 13 : 0;
      run_random(PHASE_ITEMS);
      drain_results();
    end
    walk_rows(25, rows.size() - 1);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && step_results_due.size() == 0) begin
      $display("[tiny_16bit_cpu_step_top] OK");
    end else begin
      $display("[tiny_16bit_cpu_step_top] ERROR");
    end
    $finish;
  end

endmodule

[tiny_16bit_cpu_step_top.f]
+incdir+src
src/t16c_pkg.sv
src/t16c_mem.sv
src/t16c_rf.sv
src/t16c_exec.sv
src/tiny_16bit_cpu_step_top.sv
test/tiny_16bit_cpu_step_top_tb.sv
